/* sv/matrix4x4_multiply_defines.svh */
// Assertion macros used by the matrix multiply top level.
`ifndef MATRIX4X4_MULTIPLY_DEFINES_SVH
`define MATRIX4X4_MULTIPLY_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define MM4_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define MM4_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/mm4_pkg.sv */
// Types and constants shared by the matrix multiply modules.
package mm4_pkg;

	localparam int DIM    = 4;
	localparam int CELLS  = DIM * DIM;
	localparam int DIM_W  = $clog2(DIM);
	localparam int ADDR_W = $clog2(CELLS);
	localparam int IDX_W  = 4;
	localparam int DATA_W = 32;
	localparam int PROD_W = 2 * DATA_W;
	localparam int FRAC_W = 16;
	localparam int ACC_W  = PROD_W + DIM_W + 1;

	typedef struct packed {
		logic [IDX_W-1:0]         elem_index;
		logic signed [DATA_W-1:0] left_value;
		logic signed [DATA_W-1:0] right_value;
		logic                     last_elem;
	} mm4_cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0]         out_index;
		logic signed [DATA_W-1:0] out_value;
		logic                     saturated;
		logic                     last_result;
	} mm4_res_t;

	typedef struct packed {
		logic              first;
		logic              fin;
		logic [IDX_W-1:0]  idx;
		logic              last;
	} mm4_tag_t;

endpackage

/* sv/matrix4x4_multiply.sv */
// Top level: element loading, product sequencing, rounding, saturation and result register.
// One cycle per loaded element; the last element starts DIM^3 = 64 multiply-accumulate
// steps on one shared multiplier, one step per cycle unless the result output stalls,
// reading both memories per step. Sums pass the read, product and accumulator registers
// on to the result register; new elements stall until the final result has been taken.
// Reset clears all control state; the operand memories hold no defined value until written.
`include "matrix4x4_multiply_defines.svh"

module matrix4x4_multiply import mm4_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_stall,
	input  mm4_cmd_t cmd,
	output logic     res_valid,
	input  logic     res_stall,
	output mm4_res_t res
);

	localparam logic [DIM_W-1:0] LAST_POS = DIM_W'(DIM - 1);

	logic                     cmd_accept;
	logic                     adv;
	logic                     issue;
	logic                     busy;
	logic                     run_q;
	logic [DIM_W-1:0]         e_q;
	logic [DIM_W-1:0]         x_q;
	logic [DIM_W-1:0]         y_q;
	logic                     we;
	logic [ADDR_W-1:0]        laddr;
	logic [ADDR_W-1:0]        raddr;
	logic [ADDR_W-1:0]        oaddr;
	mm4_tag_t                 tag_issue;
	logic                     v_s1;
	mm4_tag_t                 tag_s1;
	logic signed [DATA_W-1:0] ldata;
	logic signed [DATA_W-1:0] rdata;
	logic                     sum_valid;
	mm4_tag_t                 sum_tag;
	logic signed [ACC_W-1:0]  sum;
	logic                     pipe_busy;
	logic [ACC_W-FRAC_W-DATA_W:0] upper;
	logic                     pos_ovf;
	logic                     neg_ovf;
	mm4_res_t                 res_next;
	logic                     res_valid_q;
	mm4_res_t                 res_q;

	assign adv        = !(res_valid_q && res_stall);
	assign busy       = run_q || v_s1 || pipe_busy || res_valid_q;
	assign cmd_stall  = busy;
	assign cmd_accept = cmd_valid && !cmd_stall;
	assign issue      = run_q && adv;
	assign we         = cmd_accept && (32'(cmd.elem_index) < CELLS);

	assign laddr = ADDR_W'(x_q) + ADDR_W'(DIM) * ADDR_W'(e_q);
	assign raddr = ADDR_W'(e_q) + ADDR_W'(DIM) * ADDR_W'(y_q);
	assign oaddr = ADDR_W'(x_q) + ADDR_W'(DIM) * ADDR_W'(y_q);

	always_comb begin
		tag_issue.first = (e_q == '0);
		tag_issue.fin   = (e_q == LAST_POS);
		tag_issue.idx   = IDX_W'(oaddr);
		tag_issue.last  = (e_q == LAST_POS) && (x_q == LAST_POS) && (y_q == LAST_POS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			e_q   <= '0;
			x_q   <= '0;
			y_q   <= '0;
		end else if (cmd_accept && cmd.last_elem) begin
			run_q <= 1'b1;
			e_q   <= '0;
			x_q   <= '0;
			y_q   <= '0;
		end else if (issue) begin
			if (tag_issue.last) begin
				run_q <= 1'b0;
			end
			if (e_q == LAST_POS) begin
				e_q <= '0;
				if (x_q == LAST_POS) begin
					x_q <= '0;
					y_q <= (y_q == LAST_POS) ? '0 : y_q + 1'b1;
				end else begin
					x_q <= x_q + 1'b1;
				end
			end else begin
				e_q <= e_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1 <= tag_issue;
		end
	end

	mm4_store u_store (
		.clk    (clk),
		.we     (we),
		.waddr  (ADDR_W'(cmd.elem_index)),
		.wleft  (cmd.left_value),
		.wright (cmd.right_value),
		.re     (issue),
		.laddr  (laddr),
		.raddr  (raddr),
		.ldata  (ldata),
		.rdata  (rdata)
	);

	mm4_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (v_s1),
		.in_tag    (tag_s1),
		.ldata     (ldata),
		.rdata     (rdata),
		.sum_valid (sum_valid),
		.sum_tag   (sum_tag),
		.sum       (sum),
		.pipe_busy (pipe_busy)
	);

	// The half LSB was added with the first product, so dropping the fraction rounds.
	assign upper   = sum[ACC_W-1:FRAC_W+DATA_W-1];
	assign pos_ovf = !sum[ACC_W-1] && (|upper);
	assign neg_ovf = sum[ACC_W-1] && !(&upper);

	always_comb begin
		res_next.out_index   = sum_tag.idx;
		res_next.saturated   = pos_ovf || neg_ovf;
		res_next.last_result = sum_tag.last;
		if (pos_ovf) begin
			res_next.out_value = {1'b0, {(DATA_W-1){1'b1}}};
		end else if (neg_ovf) begin
			res_next.out_value = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			res_next.out_value = sum[FRAC_W+DATA_W-1:FRAC_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= sum_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && sum_valid) begin
			res_q <= res_next;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`MM4_ASSERT(a_last_index, res_valid_q && res_q.last_result, res_q.out_index == IDX_W'(CELLS - 1), "final result carries wrong index")
	`MM4_ASSERT_NEXT(a_issue_reaches_s1, issue, v_s1, "issued read did not reach the memory output stage")
	`MM4_ASSERT_NEXT(a_drained_after_last, res_valid_q && !res_stall && res_q.last_result, !run_q && !v_s1 && !pipe_busy, "work remains after final result")

endmodule

/* sv/mm4_store.sv */
// Left and right operand memories with one write port and registered reads.
module mm4_store import mm4_pkg::*; (
	input  logic                     clk,
	input  logic                     we,
	input  logic [ADDR_W-1:0]        waddr,
	input  logic signed [DATA_W-1:0] wleft,
	input  logic signed [DATA_W-1:0] wright,
	input  logic                     re,
	input  logic [ADDR_W-1:0]        laddr,
	input  logic [ADDR_W-1:0]        raddr,
	output logic signed [DATA_W-1:0] ldata,
	output logic signed [DATA_W-1:0] rdata
);

	logic signed [DATA_W-1:0] lmem [CELLS];
	logic signed [DATA_W-1:0] rmem [CELLS];

	always_ff @(posedge clk) begin
		if (we) begin
			lmem[waddr] <= wleft;
			rmem[waddr] <= wright;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			ldata <= lmem[laddr];
			rdata <= rmem[raddr];
		end
	end

endmodule

/* sv/mm4_mac.sv */
// Shared multiply-accumulate unit: product register, then exact running sum.
module mm4_mac import mm4_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic                     in_valid,
	input  mm4_tag_t                 in_tag,
	input  logic signed [DATA_W-1:0] ldata,
	input  logic signed [DATA_W-1:0] rdata,
	output logic                     sum_valid,
	output mm4_tag_t                 sum_tag,
	output logic signed [ACC_W-1:0]  sum,
	output logic                     pipe_busy
);

	localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_W - 1);

	logic                     v_s2;
	logic                     v_s3;
	mm4_tag_t                 tag_s2;
	mm4_tag_t                 tag_s3;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic [ACC_W-1:0]         prod_ext;

	assign prod_ext = {{(ACC_W - PROD_W){prod_s2[PROD_W-1]}}, prod_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s2 <= in_valid;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s2  <= in_tag;
			prod_s2 <= ldata * rdata;
			tag_s3  <= tag_s2;
			if (v_s2) begin
				if (tag_s2.first) begin
					acc_q <= prod_ext + ROUND_HALF;
				end else begin
					acc_q <= acc_q + prod_ext;
				end
			end
		end
	end

	assign sum_valid = v_s3 && tag_s3.fin;
	assign sum_tag   = tag_s3;
	assign sum       = acc_q;
	assign pipe_busy = v_s2 || v_s3;

endmodule
